/* rtl/vlps_pkg.sv */
// Package: shared constants for the video line phase sampler.
package vlps_pkg;

  localparam int ROWS_DEF     = 32;
  localparam int COLUMNS_DEF  = 80;
  localparam int SAMPLES_DEF  = 8;
  localparam int LOCK_SAMPLES = 8;
  localparam int PHASE_STRIDE = 10;
  localparam int SAMPLE_W     = 8;

  localparam int THRESH_W = 11;
  localparam int PERIOD_W = 10;
  localparam int PHASE_W  = 4;
  localparam int RROW_W   = 5;
  localparam int RCOL_W   = 7;
  localparam int OROW_W   = 5;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [CFG_AW-1:0] REG_THRESHOLD = 4'h0;
  localparam logic [CFG_AW-1:0] REG_PERIOD    = 4'h4;
  localparam logic [CFG_AW-1:0] REG_PHASES    = 4'h8;

  localparam logic [THRESH_W-1:0] THRESHOLD_RST = 11'd400;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 10'd4;
  localparam logic [PHASE_W-1:0]  PHASES_RST    = 4'd10;

  // result beat layout
  localparam int OUT_LOCKED_BIT   = 0;
  localparam int OUT_CAPTURED_BIT = 1;
  localparam int OUT_ROW_LSB      = 2;
  localparam int OUT_PHASE_LSB    = 7;
  localparam int OUT_DONE_BIT     = 11;
  localparam int OUT_PIXEL_LSB    = 12;

endpackage

/* rtl/vlps_ram.sv */
// Generic simple dual-port RAM with registered read.
module vlps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2560
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* rtl/video_line_phase_sampler_core.sv */
// Top level: equivalent-time video line sampler with pixel store.
// Input beat to result beat: an unlocked event or a zero-period skip goes to
// the done state, a capture via the write state (one store write per cycle), a
// locked skip via the bit-serial remainder (11 steps), reads via the read states.
// One item in flight; the next beat is taken while a result waits.
// Synchronous active-low reset clears control state; the store is not cleared.
module video_line_phase_sampler_core
  import vlps_pkg::*;
#(
  parameter int ROWS    = ROWS_DEF,
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int SAMPLES = SAMPLES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // sample_0..sample_7, read_row, read_column, zero pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // action
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // locked, captured, current_row, current_phase, sweep_done, pixel, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CFG_AW-1:0]      cfg_paddr,
  input  logic [CFG_DW-1:0]      cfg_pwdata,
  output logic [CFG_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  localparam int DEPTH = ROWS * COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(ROWS);
  localparam int IW    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int REM_W = PERIOD_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_WRITE, S_MOD, S_RD_ADDR, S_RD_DATA, S_DONE
  } state_t;

  state_t state_r;

  logic [THRESH_W-1:0] thresh_r;
  logic [PERIOD_W-1:0] period_r;
  logic [PHASE_W-1:0]  phases_r;

  logic                lock_r;
  logic [PERIOD_W-1:0] skip_r;
  logic [RW-1:0]       row_r;
  logic [PHASE_W-1:0]  phase_r;
  logic                done_r;

  logic                cap_r;
  logic [SAMPLE_W-1:0] pix_r;
  logic [SAMPLE_W-1:0] samp_r [SAMPLES];
  logic [RW-1:0]       cap_row_r;
  logic [PHASE_W-1:0]  cap_phase_r;
  logic [IW-1:0]       idx_r;
  logic [REM_W-1:0]    num_r;
  logic [REM_W-1:0]    rem_r;
  logic [3:0]          step_r;
  logic [RROW_W-1:0]   rd_row_r;
  logic [RCOL_W-1:0]   rd_col_r;
  logic                rd_ok_r;

  logic                   out_tvalid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  logic                cfg_wr;
  logic                in_acc;
  logic                out_free;
  logic [THRESH_W-1:0] lock_sum;
  logic [RW:0]         row_inc;
  logic                row_wrap;
  logic [PHASE_W-1:0]  phase_inc;
  logic                phase_hit;
  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    rem_next;
  logic [8:0]          wr_col;
  logic                wr_col_ok;
  logic                rd_ok;
  logic [RW+OROW_W-1:0] row_ext;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr)
      REG_THRESHOLD: cfg_prdata = CFG_DW'(thresh_r);
      REG_PERIOD:    cfg_prdata = CFG_DW'(period_r);
      REG_PHASES:    cfg_prdata = CFG_DW'(phases_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESHOLD_RST;
      period_r <= PERIOD_RST;
      phases_r <= PHASES_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr == REG_THRESHOLD) begin
        thresh_r <= cfg_pwdata[THRESH_W-1:0];
      end
      if (cfg_paddr == REG_PERIOD) begin
        period_r <= cfg_pwdata[PERIOD_W-1:0];
      end
      if (cfg_paddr == REG_PHASES) begin
        phases_r <= cfg_pwdata[PHASE_W-1:0];
      end
    end
  end

  // handshake
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // lock sum over all eight samples
  always_comb begin
    lock_sum = '0;
    for (int i = 0; i < LOCK_SAMPLES; i++) begin
      lock_sum = lock_sum + THRESH_W'(in_tdata[SAMPLE_W*i +: SAMPLE_W]);
    end
  end

  // row and phase advance on capture
  assign row_inc   = {1'b0, row_r} + 1'b1;
  assign row_wrap  = (row_inc == (RW+1)'(ROWS));
  assign phase_inc = row_wrap ? phase_r + 1'b1 : phase_r;
  assign phase_hit = (phase_inc == phases_r);

  // one remainder step
  assign rem_sh   = {rem_r[REM_W-2:0], num_r[REM_W-1]};
  assign rem_next = (rem_sh >= {1'b0, period_r}) ? rem_sh - {1'b0, period_r} : rem_sh;

  // store write column for the current sample
  assign wr_col    = 9'(cap_phase_r) + 9'(idx_r) * 9'(PHASE_STRIDE);
  assign wr_col_ok = (wr_col < 9'(COLUMNS));

  assign rd_ok = (9'(in_tdata[64 +: RROW_W]) < 9'(ROWS)) &&
                 (9'(in_tdata[69 +: RCOL_W]) < 9'(COLUMNS));

  assign row_ext = {{OROW_W{1'b0}}, row_r};

  always_comb begin
    ram_we    = (state_r == S_WRITE) && wr_col_ok;
    ram_waddr = AW'(cap_row_r * COLUMNS) + AW'(wr_col);
    ram_wdata = samp_r[idx_r];
    ram_re    = (state_r == S_RD_ADDR);
    ram_raddr = rd_ok_r ? AW'(rd_row_r * COLUMNS) + AW'(rd_col_r) : '0;
  end

  vlps_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      lock_r       <= 1'b0;
      skip_r       <= '0;
      row_r        <= '0;
      phase_r      <= '0;
      done_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cap_r <= 1'b0;
            pix_r <= '0;
            for (int i = 0; i < SAMPLES; i++) begin
              samp_r[i] <= in_tdata[SAMPLE_W*i +: SAMPLE_W];
            end
            if (in_tuser) begin
              rd_row_r <= in_tdata[64 +: RROW_W];
              rd_col_r <= in_tdata[69 +: RCOL_W];
              rd_ok_r  <= rd_ok;
              state_r  <= S_RD_ADDR;
            end else if (!lock_r) begin
              if (lock_sum < thresh_r) begin
                lock_r <= 1'b1;
              end
              state_r <= S_DONE;
            end else if (skip_r == '0) begin
              cap_r       <= 1'b1;
              skip_r      <= PERIOD_W'(1);
              cap_row_r   <= row_r;
              cap_phase_r <= phase_r;
              idx_r       <= '0;
              row_r       <= row_wrap ? '0 : row_inc[RW-1:0];
              phase_r     <= phase_hit ? '0 : phase_inc;
              if (row_wrap || phase_hit) begin
                lock_r <= 1'b0;
              end
              if (phase_hit) begin
                done_r <= 1'b1;
              end
              state_r <= S_WRITE;
            end else if (period_r == '0) begin
              skip_r  <= skip_r + 1'b1;
              state_r <= S_DONE;
            end else begin
              num_r   <= {1'b0, skip_r} + 1'b1;
              rem_r   <= '0;
              step_r  <= 4'(REM_W);
              state_r <= S_MOD;
            end
          end
        end
        S_WRITE: begin
          idx_r <= idx_r + 1'b1;
          if (idx_r == IW'(SAMPLES - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_MOD: begin
          rem_r  <= rem_next;
          num_r  <= {num_r[REM_W-2:0], 1'b0};
          step_r <= step_r - 1'b1;
          if (step_r == 4'd1) begin
            skip_r  <= rem_next[PERIOD_W-1:0];
            state_r <= S_DONE;
          end
        end
        S_RD_ADDR: begin
          state_r <= S_RD_DATA;
        end
        S_RD_DATA: begin
          pix_r   <= rd_ok_r ? ram_rdata : '0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_tdata_r  <= {4'b0, pix_r, done_r, phase_r, row_ext[OROW_W-1:0],
                             cap_r, lock_r};
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/vlps_checker.sv */
// Port-level checker for the video line phase sampler, with bind.
module vlps_checker
  import vlps_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [1:0] pend_r;
  logic       done_seen_r;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_tvalid && in_tready;
  assign out_beat = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      done_seen_r <= 1'b0;
    end else begin
      pend_r <= pend_r + 2'(in_beat) - 2'(out_beat);
      if (out_beat && out_tdata[OUT_DONE_BIT]) begin
        done_seen_r <= 1'b1;
      end
    end
  end

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two items outstanding");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> pend_r != 2'd0)
    else $error("result beat without an accepted item");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result beat changed");

  a_cap_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_CAPTURED_BIT] |->
      out_tdata[OUT_PIXEL_LSB +: 8] == 8'd0)
    else $error("capture beat carries a pixel");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && done_seen_r |-> out_tdata[OUT_DONE_BIT])
    else $error("sweep_done dropped");

endmodule

bind video_line_phase_sampler_core vlps_checker u_vlps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);
